/* rtl/nwc_pkg.sv */
package nwc_pkg;

   localparam int MAX_SIDE_DEF   = 1024;
   localparam int PIXEL_BITS_DEF = 16;

   localparam int KERNEL_SIDE    = 3;
   localparam int DIVISOR        = KERNEL_SIDE * KERNEL_SIDE;
   localparam int REM_BITS       = $clog2(DIVISOR);
   localparam int DIV_DIGIT_BITS = 4;

   localparam int COEFF_BITS     = 16;
   localparam int COEFF_FRAC     = 14;
   localparam int COEFF_ROW_BITS = KERNEL_SIDE * COEFF_BITS;

   localparam int SIDE_REG_BITS  = 11;
   localparam int SIDE_RESET     = 34;

   localparam int CSR_DATA_BITS  = COEFF_ROW_BITS;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   localparam csr_index_type CSR_IMAGE_SIDE = csr_index_type'(0);
   localparam csr_index_type CSR_COEFF_TOP  = csr_index_type'(1);
   localparam csr_index_type CSR_COEFF_MID  = csr_index_type'(2);
   localparam csr_index_type CSR_COEFF_BOT  = csr_index_type'(3);

endpackage

/* rtl/nwc_if.sv */
interface nwc_req_if #(
   parameter int PIXEL_BITS = nwc_pkg::PIXEL_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface nwc_rsp_if #(
   parameter int PIXEL_BITS = nwc_pkg::PIXEL_BITS_DEF,
   parameter int COORD_BITS = $clog2(nwc_pkg::MAX_SIDE_DEF)
);
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] filtered_value;
   logic [COORD_BITS-1:0]        center_row;
   logic [COORD_BITS-1:0]        center_col;
   logic                         frame_last;

   modport source (output valid, output filtered_value, output center_row,
                   output center_col, output frame_last, input ready);
   modport sink   (input valid, input filtered_value, input center_row,
                   input center_col, input frame_last, output ready);
endinterface

/* rtl/nwc_div_cell.sv */
module nwc_div_cell #(
   parameter int WORD_BITS = 36,
   parameter int SIDE_BITS = 22
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [nwc_pkg::REM_BITS-1:0]  in_rem,
   input  logic [WORD_BITS-1:0]          in_word,
   input  logic [SIDE_BITS-1:0]          in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [nwc_pkg::REM_BITS-1:0]  out_rem,
   output logic [WORD_BITS-1:0]          out_word,
   output logic [SIDE_BITS-1:0]          out_side
);
   import nwc_pkg::*;

   localparam logic [REM_BITS:0] DIVISOR_W = (REM_BITS + 1)'(DIVISOR);

   logic                 valid_ff;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [SIDE_BITS-1:0] side_ff;
   logic [REM_BITS:0]    trial;

   // restoring division by the constant, one dividend bit per step,
   // quotient bits shift in at the bottom as dividend bits leave the top
   always_comb begin
      rem_in  = in_rem;
      word_in = in_word;
      trial   = '0;
      for (int i = 0; i < DIV_DIGIT_BITS; i++) begin
         trial   = {rem_in, word_in[WORD_BITS-1]};
         word_in = {word_in[WORD_BITS-2:0], 1'b0};
         if (trial >= DIVISOR_W) begin
            trial      = trial - DIVISOR_W;
            word_in[0] = 1'b1;
         end
         rem_in = trial[REM_BITS-1:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff  <= rem_in;
         word_ff <= word_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_word  = word_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/nwc_window.sv */
module nwc_window #(
   parameter  int MAX_SIDE   = nwc_pkg::MAX_SIDE_DEF,
   parameter  int PIXEL_BITS = nwc_pkg::PIXEL_BITS_DEF,
   localparam int COORD_BITS = $clog2(MAX_SIDE),
   localparam int META_BITS  = 2 * COORD_BITS + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   nwc_req_if.sink               req_chan,
   input  logic [COORD_BITS-1:0] last_idx,
   output logic                  win_valid,
   input  logic                  win_ready,
   output logic [nwc_pkg::KERNEL_SIDE-1:0][nwc_pkg::KERNEL_SIDE-1:0][PIXEL_BITS-1:0] win_pixels,
   output logic [META_BITS-1:0]  win_meta
);
   import nwc_pkg::*;

   localparam logic [COORD_BITS-1:0] FIRST_INNER = COORD_BITS'(KERNEL_SIDE - 1);

   logic [COORD_BITS-1:0]   row_ff, row_in;
   logic [COORD_BITS-1:0]   col_ff, col_in;
   logic                    accept, f_move, w_take;

   logic                    f_valid_ff;
   logic                    f_produce_ff, f_produce_in;
   logic [PIXEL_BITS-1:0]   f_pix_ff;
   logic [COORD_BITS-1:0]   f_col_ff;
   logic [META_BITS-1:0]    f_meta_ff, f_meta_in;
   logic [2*PIXEL_BITS-1:0] rd_ff;

   // upper row in the high half, lower row in the low half
   logic [2*PIXEL_BITS-1:0] line_mem [MAX_SIDE];

   logic                    w_valid_ff;
   logic [KERNEL_SIDE-1:0][KERNEL_SIDE-1:0][PIXEL_BITS-1:0] win_ff;
   logic [META_BITS-1:0]    w_meta_ff;

   assign w_take         = !w_valid_ff || win_ready;
   assign f_move         = f_valid_ff && w_take;
   assign req_chan.ready = !f_valid_ff || w_take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      f_produce_in = (row_ff >= FIRST_INNER) && (col_ff >= FIRST_INNER) &&
                     (row_ff <= last_idx) && (col_ff <= last_idx);
      f_meta_in    = {COORD_BITS'(row_ff - 1'b1), COORD_BITS'(col_ff - 1'b1),
                      (row_ff == last_idx) && (col_ff == last_idx)};
      if (col_ff >= last_idx) begin
         col_in = '0;
         row_in = (row_ff >= last_idx) ? '0 : COORD_BITS'(row_ff + 1'b1);
      end else begin
         col_in = COORD_BITS'(col_ff + 1'b1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         f_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
         win_ff     <= '0;
      end else begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (req_chan.ready) begin
            f_valid_ff <= req_chan.valid;
         end
         if (w_take) begin
            w_valid_ff <= f_valid_ff && f_produce_ff;
         end
         if (f_move) begin
            for (int kr = 0; kr < KERNEL_SIDE; kr++) begin
               for (int kc = 0; kc < KERNEL_SIDE - 1; kc++) begin
                  win_ff[kr][kc] <= win_ff[kr][kc+1];
               end
            end
            win_ff[0][KERNEL_SIDE-1]             <= rd_ff[2*PIXEL_BITS-1:PIXEL_BITS];
            win_ff[1][KERNEL_SIDE-1]             <= rd_ff[PIXEL_BITS-1:0];
            win_ff[KERNEL_SIDE-1][KERNEL_SIDE-1] <= f_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_pix_ff     <= req_chan.pixel_in;
         f_col_ff     <= col_ff;
         f_meta_ff    <= f_meta_in;
         f_produce_ff <= f_produce_in;
         rd_ff        <= line_mem[col_ff];
      end
      if (f_move) begin
         line_mem[f_col_ff] <= {rd_ff[PIXEL_BITS-1:0], f_pix_ff};
         w_meta_ff          <= f_meta_ff;
      end
   end

   assign win_valid  = w_valid_ff;
   assign win_pixels = win_ff;
   assign win_meta   = w_meta_ff;

   a_no_line_collision: assert property (@(posedge clock) disable iff (reset)
      accept && f_move |-> col_ff != f_col_ff)
      else $error("line store read and write hit the same column");

endmodule

/* rtl/normalized_window_convolution.sv */
// 3x3 convolution over a square raster frame, normalized by 9.
// req_chan carries one signed pixel per transaction in raster order; rsp_chan
// carries one result per interior window center with its row, column and a
// flag on the last interior center of the frame. Border pixels give no
// result. csr_* writes frame side (clamped to 3..MAX_SIDE) and the three
// packed coefficient rows; write only while no transaction is in flight.
// Pixel (r, c) yields center (r-1, c-1) via the window, product, row sum,
// total, magnitude, DIV_CELLS divider cell, rounding and output registers,
// DIV_CELLS = ceil((PIXEL_BITS + 20) / 4); the divider chain resolves 4
// quotient bits per cell. While rsp_chan does not stall, throughput is one
// pixel per cycle, set by the single line store read and write per cycle.
// Reset empties the pipeline, returns the counters to the frame start, sets
// side 34 and all coefficients to zero. Line store contents are not cleared.
// When rsp_chan stalls, the result holds in the output register and the
// pipeline keeps taking pixels until every stage holds a transaction.
module normalized_window_convolution #(
   parameter int MAX_SIDE   = nwc_pkg::MAX_SIDE_DEF,
   parameter int PIXEL_BITS = nwc_pkg::PIXEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   nwc_req_if.sink                      req_chan,
   nwc_rsp_if.source                    rsp_chan,
   input  logic                         csr_write_en,
   input  nwc_pkg::csr_index_type       csr_index,
   input  nwc_pkg::csr_data_type        csr_wdata
);
   import nwc_pkg::*;

   localparam int COORD_BITS    = $clog2(MAX_SIDE);
   localparam int META_BITS     = 2 * COORD_BITS + 1;
   localparam int SIDE_BITS     = META_BITS + 1;
   localparam int PROD_BITS     = PIXEL_BITS + COEFF_BITS;
   localparam int ROW_BITS      = PROD_BITS + 2;
   localparam int ACC_BITS      = PROD_BITS + 4;
   localparam int DIV_CELLS     = (ACC_BITS + DIV_DIGIT_BITS - 1) / DIV_DIGIT_BITS;
   localparam int DIV_WORD_BITS = DIV_CELLS * DIV_DIGIT_BITS;
   localparam int T_BITS        = DIV_WORD_BITS - COEFF_FRAC;

   localparam logic [COORD_BITS-1:0] LAST_IDX_RESET =
      COORD_BITS'(((SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET) - 1);
   localparam logic [PIXEL_BITS-1:0] SAT_HI = {1'b0, {(PIXEL_BITS-1){1'b1}}};
   localparam logic [PIXEL_BITS-1:0] SAT_LO = {1'b1, {(PIXEL_BITS-1){1'b0}}};

   // configuration
   logic [SIDE_REG_BITS-1:0]  side_wr;
   logic [COORD_BITS-1:0]     last_idx_ff, last_idx_in;
   logic [KERNEL_SIDE-1:0][COEFF_ROW_BITS-1:0] coeff_ff;

   always_comb begin
      side_wr = csr_wdata[SIDE_REG_BITS-1:0];
      priority if (int'(side_wr) < KERNEL_SIDE) begin
         last_idx_in = COORD_BITS'(KERNEL_SIDE - 1);
      end else if (int'(side_wr) > MAX_SIDE) begin
         last_idx_in = COORD_BITS'(MAX_SIDE - 1);
      end else begin
         last_idx_in = COORD_BITS'(side_wr - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff <= LAST_IDX_RESET;
         coeff_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_SIDE: last_idx_ff <= last_idx_in;
            CSR_COEFF_TOP:  coeff_ff[0] <= csr_wdata[COEFF_ROW_BITS-1:0];
            CSR_COEFF_MID:  coeff_ff[1] <= csr_wdata[COEFF_ROW_BITS-1:0];
            CSR_COEFF_BOT:  coeff_ff[2] <= csr_wdata[COEFF_ROW_BITS-1:0];
         endcase
      end
   end

   // line stores and window
   logic                 win_valid, win_ready;
   logic [KERNEL_SIDE-1:0][KERNEL_SIDE-1:0][PIXEL_BITS-1:0] win_pixels;
   logic [META_BITS-1:0] win_meta;

   nwc_window #(
      .MAX_SIDE   (MAX_SIDE),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .last_idx   (last_idx_ff),
      .win_valid  (win_valid),
      .win_ready  (win_ready),
      .win_pixels (win_pixels),
      .win_meta   (win_meta)
   );

   // stage handshakes
   logic prod_valid_ff, rsum_valid_ff, acc_valid_ff, mag_valid_ff;
   logic rnd_valid_ff, out_valid_ff;
   logic prod_take, rsum_take, acc_take, mag_take, rnd_take, out_take;

   logic                 dv_valid [DIV_CELLS+1];
   logic                 dv_ready [DIV_CELLS+1];
   logic [REM_BITS-1:0]  dv_rem   [DIV_CELLS+1];
   logic [DIV_WORD_BITS-1:0] dv_word [DIV_CELLS+1];
   logic [SIDE_BITS-1:0] dv_side  [DIV_CELLS+1];

   assign out_take  = !out_valid_ff || rsp_chan.ready;
   assign rnd_take  = !rnd_valid_ff || out_take;
   assign dv_ready[DIV_CELLS] = rnd_take;
   assign mag_take  = !mag_valid_ff || dv_ready[0];
   assign acc_take  = !acc_valid_ff || mag_take;
   assign rsum_take = !rsum_valid_ff || acc_take;
   assign prod_take = !prod_valid_ff || rsum_take;
   assign win_ready = prod_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsum_valid_ff <= 1'b0;
         acc_valid_ff  <= 1'b0;
         mag_valid_ff  <= 1'b0;
         rnd_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_take) prod_valid_ff <= win_valid;
         if (rsum_take) rsum_valid_ff <= prod_valid_ff;
         if (acc_take)  acc_valid_ff  <= rsum_valid_ff;
         if (mag_take)  mag_valid_ff  <= acc_valid_ff;
         if (rnd_take)  rnd_valid_ff  <= dv_valid[DIV_CELLS];
         if (out_take)  out_valid_ff  <= rnd_valid_ff;
      end
   end

   // products
   logic signed [PROD_BITS-1:0] prod_in [KERNEL_SIDE][KERNEL_SIDE];
   logic signed [PROD_BITS-1:0] prod_ff [KERNEL_SIDE][KERNEL_SIDE];
   logic [META_BITS-1:0]        prod_meta_ff;

   always_comb begin
      for (int kr = 0; kr < KERNEL_SIDE; kr++) begin
         for (int kc = 0; kc < KERNEL_SIDE; kc++) begin
            prod_in[kr][kc] = $signed(win_pixels[kr][kc]) *
                              $signed(coeff_ff[kr][kc*COEFF_BITS +: COEFF_BITS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_take) begin
         prod_ff      <= prod_in;
         prod_meta_ff <= win_meta;
      end
   end

   // row sums
   logic signed [ROW_BITS-1:0] rsum_in [KERNEL_SIDE];
   logic signed [ROW_BITS-1:0] rsum_ff [KERNEL_SIDE];
   logic [META_BITS-1:0]       rsum_meta_ff;

   always_comb begin
      for (int kr = 0; kr < KERNEL_SIDE; kr++) begin
         rsum_in[kr] = '0;
         for (int kc = 0; kc < KERNEL_SIDE; kc++) begin
            rsum_in[kr] = rsum_in[kr] + ROW_BITS'(prod_ff[kr][kc]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsum_take) begin
         rsum_ff      <= rsum_in;
         rsum_meta_ff <= prod_meta_ff;
      end
   end

   // total
   logic signed [ACC_BITS-1:0] acc_in, acc_ff;
   logic [META_BITS-1:0]       acc_meta_ff;

   always_comb begin
      acc_in = '0;
      for (int kr = 0; kr < KERNEL_SIDE; kr++) begin
         acc_in = acc_in + ACC_BITS'(rsum_ff[kr]);
      end
   end

   always_ff @(posedge clock) begin
      if (acc_take) begin
         acc_ff      <= acc_in;
         acc_meta_ff <= rsum_meta_ff;
      end
   end

   // sign and magnitude
   logic [ACC_BITS-1:0]      acc_abs;
   logic [DIV_WORD_BITS-1:0] mag_ff;
   logic [SIDE_BITS-1:0]     mag_side_ff;

   assign acc_abs = acc_ff[ACC_BITS-1] ? ACC_BITS'(-acc_ff) : ACC_BITS'(acc_ff);

   always_ff @(posedge clock) begin
      if (mag_take) begin
         mag_ff      <= DIV_WORD_BITS'(acc_abs);
         mag_side_ff <= {acc_ff[ACC_BITS-1], acc_meta_ff};
      end
   end

   // divide by 9
   assign dv_valid[0] = mag_valid_ff;
   assign dv_rem[0]   = '0;
   assign dv_word[0]  = mag_ff;
   assign dv_side[0]  = mag_side_ff;

   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
      nwc_div_cell #(
         .WORD_BITS (DIV_WORD_BITS),
         .SIDE_BITS (SIDE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[k]),
         .in_ready  (dv_ready[k]),
         .in_rem    (dv_rem[k]),
         .in_word   (dv_word[k]),
         .in_side   (dv_side[k]),
         .out_valid (dv_valid[k+1]),
         .out_ready (dv_ready[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_word  (dv_word[k+1]),
         .out_side  (dv_side[k+1])
      );
   end

   // shift by the coefficient fraction, rounding toward minus infinity
   logic [DIV_WORD_BITS-1:0] quot;
   logic                     quot_neg;
   logic [T_BITS-1:0]        rnd_in, rnd_ff;
   logic                     rnd_neg_ff;
   logic [META_BITS-1:0]     rnd_meta_ff;

   assign quot     = dv_word[DIV_CELLS];
   assign quot_neg = dv_side[DIV_CELLS][SIDE_BITS-1];
   assign rnd_in   = T_BITS'(quot[DIV_WORD_BITS-1:COEFF_FRAC]) +
                     T_BITS'(quot_neg && (quot[COEFF_FRAC-1:0] != '0));

   always_ff @(posedge clock) begin
      if (rnd_take) begin
         rnd_ff      <= rnd_in;
         rnd_neg_ff  <= quot_neg;
         rnd_meta_ff <= dv_side[DIV_CELLS][META_BITS-1:0];
      end
   end

   // saturate and hold for the receiver
   logic [PIXEL_BITS-1:0] value_in, out_value_ff;
   logic [META_BITS-1:0]  out_meta_ff;

   always_comb begin
      priority if (!rnd_neg_ff && (rnd_ff > T_BITS'(SAT_HI))) begin
         value_in = SAT_HI;
      end else if (rnd_neg_ff && (rnd_ff > T_BITS'(SAT_LO))) begin
         value_in = SAT_LO;
      end else if (rnd_neg_ff) begin
         value_in = PIXEL_BITS'(T_BITS'(0) - rnd_ff);
      end else begin
         value_in = PIXEL_BITS'(rnd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_value_ff <= value_in;
         out_meta_ff  <= rnd_meta_ff;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.filtered_value = out_value_ff;
   assign rsp_chan.center_row     = out_meta_ff[META_BITS-1 -: COORD_BITS];
   assign rsp_chan.center_col     = out_meta_ff[COORD_BITS:1];
   assign rsp_chan.frame_last     = out_meta_ff[0];

   a_last_on_diagonal: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_last |->
         rsp_chan.center_row == rsp_chan.center_col)
      else $error("frame end flagged off the last interior center");

   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.center_row != '0 && rsp_chan.center_col != '0)
      else $error("result transaction for a border center");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      dv_valid[DIV_CELLS] |-> dv_rem[DIV_CELLS] < REM_BITS'(DIVISOR))
      else $error("divider remainder out of range");

endmodule

/* verif/tb_normalized_window_convolution.sv */
`timescale 1ns / 1ps

module tb_normalized_window_convolution;
   import nwc_pkg::*;

   class window_conv_model;
      typedef struct packed {
         logic signed [15:0] value;
         logic [9:0]         row;
         logic [9:0]         col;
         logic               last;
      } conv_out_type;

      logic [SIDE_REG_BITS-1:0]  side_reg;
      logic [COEFF_ROW_BITS-1:0] coeff_rows [KERNEL_SIDE];
      logic signed [15:0]        upper_line [MAX_SIDE_DEF];
      logic signed [15:0]        lower_line [MAX_SIDE_DEF];
      logic signed [15:0]        window [KERNEL_SIDE][KERNEL_SIDE];
      int unsigned               col_count;
      int unsigned               row_count;
      conv_out_type              outstanding [$];
      int                        mismatches;

      function new();
         side_reg = SIDE_REG_BITS'(SIDE_RESET);
         foreach (coeff_rows[i]) coeff_rows[i] = '0;
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
         end
         foreach (window[i, j]) window[i][j] = '0;
         col_count = 0;
         row_count = 0;
         mismatches = 0;
      endfunction

      function void set_reg(csr_index_type idx, csr_data_type data);
         case (idx)
            CSR_IMAGE_SIDE: side_reg = data[SIDE_REG_BITS-1:0];
            CSR_COEFF_TOP:  coeff_rows[0] = data;
            CSR_COEFF_MID:  coeff_rows[1] = data;
            CSR_COEFF_BOT:  coeff_rows[2] = data;
            default: ;
         endcase
      endfunction

      function int unsigned eff_side();
         if (side_reg < 3) return 3;
         if (side_reg > MAX_SIDE_DEF) return MAX_SIDE_DEF;
         return side_reg;
      endfunction

      function logic signed [15:0] coeff_at(int kr, int kc);
         return coeff_rows[kr][COEFF_BITS*kc +: COEFF_BITS];
      endfunction

      // pixels still needed to bring the counters back to the frame start
      function int frame_remaining();
         int unsigned s, r, c;
         int n;
         s = eff_side();
         r = row_count;
         c = col_count;
         n = 0;
         if (r == 0 && c == 0) return 0;
         do begin
            n++;
            if (c + 1 >= s) begin
               c = 0;
               r = (r + 1 >= s) ? 0 : r + 1;
            end else begin
               c++;
            end
         end while (!(r == 0 && c == 0));
         return n;
      endfunction

      function void take_pixel(logic signed [15:0] pix);
         int unsigned s, r, c, idx;
         logic signed [15:0] top, mid;
         longint acc, quo, sat;
         conv_out_type res;
         s = eff_side();
         r = row_count;
         c = col_count;
         idx = (c < MAX_SIDE_DEF) ? c : MAX_SIDE_DEF - 1;
         top = upper_line[idx];
         mid = lower_line[idx];
         upper_line[idx] = mid;
         lower_line[idx] = pix;
         for (int kr = 0; kr < KERNEL_SIDE; kr++) begin
            for (int kc = 0; kc + 1 < KERNEL_SIDE; kc++) window[kr][kc] = window[kr][kc+1];
         end
         window[0][KERNEL_SIDE-1] = top;
         window[1][KERNEL_SIDE-1] = mid;
         window[2][KERNEL_SIDE-1] = pix;
         if (r >= 2 && c >= 2 && r < s && c < s) begin
            acc = 0;
            for (int kr = 0; kr < KERNEL_SIDE; kr++) begin
               for (int kc = 0; kc < KERNEL_SIDE; kc++) begin
                  acc += longint'(window[kr][kc]) * longint'(coeff_at(kr, kc));
               end
            end
            quo = acc / DIVISOR;
            sat = quo >>> COEFF_FRAC;
            if (sat > 32767) sat = 32767;
            else if (sat < -32768) sat = -32768;
            res.value = 16'(sat);
            res.row = 10'(r - 1);
            res.col = 10'(c - 1);
            res.last = (r == s - 1 && c == s - 1);
            outstanding.push_back(res);
         end
         if (c + 1 >= s) begin
            col_count = 0;
            row_count = (r + 1 >= s) ? 0 : ((r + 1) & 10'h3FF);
         end else begin
            col_count = (c + 1) & 10'h3FF;
         end
      endfunction

      task log_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      task check_result(logic signed [15:0] value, logic [9:0] row, logic [9:0] col,
                        logic last);
         conv_out_type want;
         if (outstanding.size() == 0) begin
            log_mismatch($sformatf("unexpected transaction value %0d at (%0d,%0d)",
                                   value, row, col));
            return;
         end
         want = outstanding.pop_front();
         if (value !== want.value)
            log_mismatch($sformatf("value %0d, want %0d at (%0d,%0d)",
                                   value, want.value, want.row, want.col));
         if (row !== want.row)
            log_mismatch($sformatf("center_row %0d, want %0d", row, want.row));
         if (col !== want.col)
            log_mismatch($sformatf("center_col %0d, want %0d", col, want.col));
         if (last !== want.last)
            log_mismatch($sformatf("frame_last %0b, want %0b at (%0d,%0d)",
                                   last, want.last, want.row, want.col));
      endtask
   endclass

   localparam int     CLOCK_HALF    = 4;
   localparam int     DRAIN_CYCLES  = 32;
   localparam int     RANDOM_PIXELS = 500;
   localparam int     BIG_PREFIX    = 2 * MAX_SIDE_DEF + 30;
   localparam longint CYCLE_LIMIT   = 1_500_000;

   logic          clock;
   logic          reset;
   logic          csr_write_en;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   nwc_req_if req_bus ();
   nwc_rsp_if rsp_bus ();

   window_conv_model conv_model;
   bit               sender_steady;
   bit               receiver_steady;
   int               stall_left;
   longint           cycle_count = 0;

   normalized_window_convolution uut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [15:0] random_pixel();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return 16'sh7FFF;
      if (pick == 1) return 16'sh8000;
      if (pick < 6) return 16'($urandom_range(0, 1024) - 512);
      return 16'($urandom);
   endfunction

   function automatic csr_data_type coeff_row();
      csr_data_type row;
      int pick;
      pick = $urandom_range(0, 9);
      row = csr_data_type'({$urandom, $urandom});
      if (pick == 0) begin
         row = '0;
      end else if (pick == 1) begin
         row = {KERNEL_SIDE{16'h7FFF}};
      end else if (pick == 2) begin
         row = {KERNEL_SIDE{16'h8000}};
      end else if (pick < 7) begin
         for (int k = 0; k < KERNEL_SIDE; k++)
            row[COEFF_BITS*k +: COEFF_BITS] = 16'($urandom_range(0, 32768) - 16384);
      end
      return row;
   endfunction

   function automatic logic [SIDE_REG_BITS-1:0] pick_side(int unsigned limit);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return SIDE_REG_BITS'($urandom_range(0, 2));
      if (pick < 8) return SIDE_REG_BITS'($urandom_range(3, (limit < 10) ? limit : 10));
      return SIDE_REG_BITS'($urandom_range(3, limit));
   endfunction

   // response side backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left <= receiver_steady ? 0 : gap_length();
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) conv_model.take_pixel(req_bus.pixel_in);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         conv_model.check_result(rsp_bus.filtered_value, rsp_bus.center_row,
                                 rsp_bus.center_col, rsp_bus.frame_last);
   end

   task automatic write_regs(input logic [SIDE_REG_BITS-1:0] side,
                             input csr_data_type top, input csr_data_type mid,
                             input csr_data_type bot);
      csr_index_type regs [4] = '{CSR_IMAGE_SIDE, CSR_COEFF_TOP, CSR_COEFF_MID, CSR_COEFF_BOT};
      csr_data_type  vals [4];
      vals[0] = $urandom_range(0, 1) ? csr_data_type'({$urandom, $urandom}) : '0;
      vals[0][SIDE_REG_BITS-1:0] = side;
      vals[1] = top;
      vals[2] = mid;
      vals[3] = bot;
      for (int i = 0; i < 4; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         conv_model.set_reg(regs[i], vals[i]);
      end
      csr_write_en <= 1'b0;
   endtask

   task automatic drive_pixel(input logic signed [15:0] pix, input int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_in <= pix;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (conv_model.outstanding.size() != 0);
   endtask

   task automatic settle();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_pixels(input int count, input int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            req_bus.valid <= 1'b0;
            wait_drained();
         end
         drive_pixel(random_pixel(), sender_steady ? 0 : gap_length());
      end
      req_bus.valid <= 1'b0;
   endtask

   task automatic send_listed(input logic signed [15:0] pix [9]);
      foreach (pix[i]) drive_pixel(pix[i], sender_steady ? 0 : gap_length());
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      logic signed [15:0] frame_px [9];
      int random_sent;
      int count;
      int pause_at;
      bit first_phase;
      bit mid_frame;

      conv_model = new();
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.pixel_in <= '0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_IMAGE_SIDE;
      csr_wdata <= '0;
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // side below 3, full-scale kernel: positive saturation
      write_regs(SIDE_REG_BITS'(0), {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
      frame_px = '{default: 16'sh7FFF};
      send_listed(frame_px);
      settle();

      // most negative kernel: negative saturation
      write_regs(SIDE_REG_BITS'(2), {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
      send_listed(frame_px);
      settle();

      // unit center tap: truncation of negative sums, then floor shift
      write_regs(SIDE_REG_BITS'(1), '0, {16'h0000, 16'h4000, 16'h0000}, '0);
      frame_px = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sh8000, -16'sd1,
                   16'sh0000, 16'sh7FFF, 16'sh8000};
      send_listed(frame_px);
      settle();

      // side above the maximum, only the first rows of the frame
      write_regs(SIDE_REG_BITS'($urandom_range(MAX_SIDE_DEF + 1, 2047)),
                 coeff_row(), coeff_row(), coeff_row());
      send_pixels(BIG_PREFIX, -1);

      random_sent = 0;
      first_phase = 1'b1;
      while (random_sent < RANDOM_PIXELS) begin
         settle();
         mid_frame = conv_model.frame_remaining() != 0;
         write_regs(pick_side(mid_frame ? conv_model.eff_side() : 40),
                    coeff_row(), coeff_row(), coeff_row());
         sender_steady = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         count = conv_model.frame_remaining();
         if (count == 0) count = conv_model.eff_side() * conv_model.eff_side();
         if (!first_phase && $urandom_range(0, 5) == 0) count = $urandom_range(1, count);
         if (count > RANDOM_PIXELS - random_sent) count = RANDOM_PIXELS - random_sent;
         if (first_phase) pause_at = count / 2;
         else pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, count - 1) : -1;
         send_pixels(count, pause_at);
         random_sent += count;
         first_phase = 1'b0;
      end

      settle();
      if (conv_model.mismatches == 0 && conv_model.outstanding.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
